/* src/sspp_pkg.sv */
// ----------------------------------------------------------------------------
// Servo status packet parser package
// Result codes, register indexes and the result word shared by the parser.
// ----------------------------------------------------------------------------
package sspp_pkg;

	localparam logic [7:0] MARK_BYTE   = 8'hFF;
	localparam logic [7:0] MAX_ID      = 8'hFD;
	localparam logic [7:0] HDR_LEN_MIN = 8'd2;
	localparam logic [7:0] MAX_PAYLOAD_RST = 8'd253;
	localparam logic [7:0] ALARM_MASK_RST  = 8'h5A;

	// Configuration register indexes.
	localparam logic REG_MAX_PAYLOAD = 1'b0;
	localparam logic REG_ALARM_MASK  = 1'b1;

	typedef enum logic [2:0] {
		KIND_PAYLOAD  = 3'd0,
		KIND_GOOD     = 3'd1,
		KIND_CHECKSUM = 3'd2,
		KIND_BAD_HDR  = 3'd3,
		KIND_TOO_LONG = 3'd4,
		KIND_ABORTED  = 3'd5
	} kind_t;

	typedef struct packed {
		kind_t      kind;
		logic [7:0] payload_byte;
		logic [7:0] payload_index;
		logic [7:0] packet_id;
		logic [7:0] device_status;
		logic [7:0] payload_length;
		logic       alarm;
	} result_t;

endpackage

/* src/servo_status_packet_parser_core.sv */
// A result is registered and appears on the output in the cycle after the word that causes it.
// Throughput: one received word per cycle; the next word is taken while a result
// waits, as long as the output register is free or being drained in that cycle.
// Reset clears the packet state, the output valid flag and sets the registers
// to max_payload 253 and alarm_mask 0x5A; no clearing pass is needed.
// ----------------------------------------------------------------------------
// Servo status packet parser core
// Parses status packets from a half-duplex servo bus, one received word at a
// time, and reports payload words and a final packet status.
// ----------------------------------------------------------------------------
module servo_status_packet_parser_core (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] rx_byte,
	input  logic       abort,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [2:0] kind,
	output logic [7:0] payload_byte,
	output logic [7:0] payload_index,
	output logic [7:0] packet_id,
	output logic [7:0] device_status,
	output logic [7:0] payload_length,
	output logic       alarm,
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic       cfg_index,
	input  logic [7:0] cfg_data
);

	logic [7:0] max_payload_q;
	logic [7:0] alarm_mask_q;
	logic       out_valid_q;
	sspp_pkg::result_t out_q;
	sspp_pkg::result_t res;
	logic       res_valid;
	logic       in_take;

	assign cfg_ready = 1'b1;
	assign in_ready  = !out_valid_q || out_ready;
	assign in_take   = in_valid && in_ready;

	sspp_engine u_engine (
		.clk         (clk),
		.arst_n      (arst_n),
		.step        (in_take),
		.rx_byte     (rx_byte),
		.abort       (abort),
		.max_payload (max_payload_q),
		.alarm_mask  (alarm_mask_q),
		.res_valid   (res_valid),
		.res         (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_payload_q <= sspp_pkg::MAX_PAYLOAD_RST;
			alarm_mask_q  <= sspp_pkg::ALARM_MASK_RST;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				sspp_pkg::REG_MAX_PAYLOAD: max_payload_q <= cfg_data;
				sspp_pkg::REG_ALARM_MASK:  alarm_mask_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (in_take && res_valid) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_take && res_valid) begin
			out_q <= res;
		end
	end

	assign out_valid      = out_valid_q;
	assign kind           = out_q.kind;
	assign payload_byte   = out_q.payload_byte;
	assign payload_index  = out_q.payload_index;
	assign packet_id      = out_q.packet_id;
	assign device_status  = out_q.device_status;
	assign payload_length = out_q.payload_length;
	assign alarm          = out_q.alarm;

	a_load_shows: assert property (@(posedge clk) disable iff (!arst_n)
		(in_take && res_valid) |=> out_valid_q)
		else $error("result word was lost");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !out_ready) |-> !in_take)
		else $error("input taken while output word is stalled");

	a_drain: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_ready && !(in_take && res_valid)) |=> !out_valid_q)
		else $error("result word repeated");

endmodule

/* src/sspp_engine.sv */
// ----------------------------------------------------------------------------
// Servo status packet parser engine
// Holds the packet state and works out the result word for one received word.
// ----------------------------------------------------------------------------
module sspp_engine (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              step,
	input  logic [7:0]        rx_byte,
	input  logic              abort,
	input  logic [7:0]        max_payload,
	input  logic [7:0]        alarm_mask,
	output logic              res_valid,
	output sspp_pkg::result_t res
);

	typedef enum logic [1:0] {
		PH_HEADER  = 2'd0,
		PH_PAYLOAD = 2'd1,
		PH_CHECK   = 2'd2
	} phase_t;

	phase_t     phase_q, phase_d;
	logic [2:0] hdr_cnt_q, hdr_cnt_d;
	logic       hdr_bad_q, hdr_bad_d;
	logic [7:0] id_q, id_d;
	logic [7:0] len_q, len_d;
	logic [7:0] stat_q, stat_d;
	logic [7:0] sum_q, sum_d;
	logic [7:0] cnt_q, cnt_d;

	logic [7:0] plen_q;
	logic [7:0] plen_d;
	logic [7:0] cnt_inc;
	logic       info;
	sspp_pkg::kind_t kind_c;
	logic [7:0] byte_c, index_c, plen_c;

	assign plen_q  = len_q - sspp_pkg::HDR_LEN_MIN;
	assign plen_d  = len_d - sspp_pkg::HDR_LEN_MIN;
	assign cnt_inc = cnt_q + 8'd1;

	always_comb begin
		phase_d   = phase_q;
		hdr_cnt_d = hdr_cnt_q;
		hdr_bad_d = hdr_bad_q;
		id_d      = id_q;
		len_d     = len_q;
		stat_d    = stat_q;
		sum_d     = sum_q;
		cnt_d     = cnt_q;
		res_valid = 1'b0;
		info      = 1'b0;
		kind_c    = sspp_pkg::KIND_ABORTED;
		byte_c    = 8'd0;
		index_c   = 8'd0;
		plen_c    = 8'd0;
		if (abort) begin
			phase_d   = PH_HEADER;
			hdr_cnt_d = 3'd0;
			hdr_bad_d = 1'b0;
			res_valid = 1'b1;
		end else begin
			unique case (phase_q)
				PH_PAYLOAD: begin
					sum_d     = sum_q + rx_byte;
					cnt_d     = cnt_inc;
					if (cnt_inc >= plen_q) begin
						phase_d = PH_CHECK;
					end
					res_valid = 1'b1;
					info      = 1'b1;
					kind_c    = sspp_pkg::KIND_PAYLOAD;
					byte_c    = rx_byte;
					index_c   = cnt_q;
					plen_c    = plen_q;
				end
				PH_CHECK: begin
					phase_d   = PH_HEADER;
					hdr_cnt_d = 3'd0;
					hdr_bad_d = 1'b0;
					res_valid = 1'b1;
					info      = 1'b1;
					if (~sum_q == rx_byte) begin
						kind_c = sspp_pkg::KIND_GOOD;
						plen_c = plen_q;
					end else begin
						kind_c = sspp_pkg::KIND_CHECKSUM;
					end
				end
				default: begin
					// Header gathering; the unused phase code lands here as well.
					unique case (hdr_cnt_q)
						3'd0, 3'd1: begin
							if (rx_byte != sspp_pkg::MARK_BYTE) begin
								hdr_bad_d = 1'b1;
							end
						end
						3'd2: begin
							id_d = rx_byte;
							if (rx_byte > sspp_pkg::MAX_ID) begin
								hdr_bad_d = 1'b1;
							end
						end
						3'd3: begin
							len_d = rx_byte;
							if (rx_byte < sspp_pkg::HDR_LEN_MIN) begin
								hdr_bad_d = 1'b1;
							end
						end
						default: begin
							stat_d = rx_byte;
						end
					endcase
					phase_d = PH_HEADER;
					if (hdr_cnt_q < 3'd4) begin
						hdr_cnt_d = hdr_cnt_q + 3'd1;
					end else if (hdr_bad_d) begin
						hdr_cnt_d = 3'd0;
						hdr_bad_d = 1'b0;
						res_valid = 1'b1;
						info      = 1'b1;
						kind_c    = sspp_pkg::KIND_BAD_HDR;
					end else if (plen_d > max_payload) begin
						hdr_cnt_d = 3'd0;
						hdr_bad_d = 1'b0;
						res_valid = 1'b1;
						info      = 1'b1;
						kind_c    = sspp_pkg::KIND_TOO_LONG;
					end else begin
						sum_d     = id_d + len_d + stat_d;
						cnt_d     = 8'd0;
						hdr_cnt_d = 3'd0;
						hdr_bad_d = 1'b0;
						phase_d   = (plen_d == 8'd0) ? PH_CHECK : PH_PAYLOAD;
					end
				end
			endcase
		end
	end

	always_comb begin
		res.kind           = kind_c;
		res.payload_byte   = byte_c;
		res.payload_index  = index_c;
		res.packet_id      = info ? id_d : 8'd0;
		res.device_status  = info ? stat_d : 8'd0;
		res.payload_length = plen_c;
		res.alarm          = info && ((stat_d & alarm_mask) != 8'd0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_HEADER;
			hdr_cnt_q <= 3'd0;
			hdr_bad_q <= 1'b0;
			id_q      <= 8'd0;
			len_q     <= 8'd0;
			stat_q    <= 8'd0;
			sum_q     <= 8'd0;
			cnt_q     <= 8'd0;
		end else if (step) begin
			phase_q   <= phase_d;
			hdr_cnt_q <= hdr_cnt_d;
			hdr_bad_q <= hdr_bad_d;
			id_q      <= id_d;
			len_q     <= len_d;
			stat_q    <= stat_d;
			sum_q     <= sum_d;
			cnt_q     <= cnt_d;
		end
	end

	a_hdr_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		hdr_cnt_q <= 3'd4)
		else $error("header count out of range");

	a_abort_result: assert property (@(posedge clk) disable iff (!arst_n)
		abort |-> (res_valid && res.kind == sspp_pkg::KIND_ABORTED
			&& res.packet_id == 8'd0 && !res.alarm))
		else $error("abort did not give an aborted result");

	a_payload_result: assert property (@(posedge clk) disable iff (!arst_n)
		(!abort && phase_q == PH_PAYLOAD) |->
			(res_valid && res.kind == sspp_pkg::KIND_PAYLOAD && res.payload_byte == rx_byte))
		else $error("payload word did not pass through");

	a_header_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		(!abort && phase_q != PH_PAYLOAD && phase_q != PH_CHECK && hdr_cnt_q < 3'd4)
			|-> !res_valid)
		else $error("result during header gathering");

endmodule

/* sim/tb_servo_status_packet_parser_core.sv */
// ----------------------------------------------------------------------------
// Servo status packet parser core testbench
// Streams status packets and noise into the parser with random gaps and
// stalls. Each result is checked against a behavioral parser kept in the bench.
// ----------------------------------------------------------------------------
module tb_servo_status_packet_parser_core;

	localparam int WATCHDOG_LIMIT = 1000;

	typedef enum logic [1:0] {SCAN_HEADER, SCAN_PAYLOAD, SCAN_CHECK} scan_t;

	typedef struct packed {
		logic [7:0] data;
		logic       abort_bit;
	} rx_word_t;

	logic       clk;
	logic       arst_n = 1'b0;
	logic       in_valid = 1'b0;
	logic       in_ready;
	logic [7:0] rx_byte = '0;
	logic       abort = 1'b0;
	logic       out_valid;
	logic       out_ready = 1'b0;
	logic [2:0] kind;
	logic [7:0] payload_byte;
	logic [7:0] payload_index;
	logic [7:0] packet_id;
	logic [7:0] device_status;
	logic [7:0] payload_length;
	logic       alarm;
	logic       cfg_valid = 1'b0;
	logic       cfg_ready;
	logic       cfg_index = 1'b0;
	logic [7:0] cfg_data = '0;

	// Words waiting to be driven and results the parser still owes.
	rx_word_t   rx_words[$];
	sspp_pkg::result_t awaited_results[$];
	logic [7:0] frame[$];

	// Bench copy of the registers and the parser state.
	logic [7:0] max_payload_reg;
	logic [7:0] alarm_mask_reg;
	scan_t      scan;
	logic [2:0] hdr_count;
	logic       hdr_bad;
	logic [7:0] seen_id;
	logic [7:0] seen_len;
	logic [7:0] seen_status;
	logic [7:0] csum;
	logic [7:0] body_count;

	int         mismatches = 0;
	int         results_seen = 0;
	int         words_queued = 0;
	int         idle_cycles = 0;
	int         gap_left = 0;
	int         stall_left = 0;
	bit         drv_steady = 0;
	bit         mon_steady = 0;
	rx_word_t   next_word;

	servo_status_packet_parser_core DUT (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.rx_byte(rx_byte),
		.abort(abort),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.kind(kind),
		.payload_byte(payload_byte),
		.payload_index(payload_index),
		.packet_id(packet_id),
		.device_status(device_status),
		.payload_length(payload_length),
		.alarm(alarm),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic void restart_scan();
		scan = SCAN_HEADER;
		hdr_count = '0;
		hdr_bad = 1'b0;
	endfunction

	function automatic void owe_result(input sspp_pkg::kind_t k, input logic [7:0] data,
		input logic [7:0] idx, input logic [7:0] plen, input bit info);
		sspp_pkg::result_t r;
		r.kind = k;
		r.payload_byte = data;
		r.payload_index = idx;
		r.packet_id = info ? seen_id : 8'h00;
		r.device_status = info ? seen_status : 8'h00;
		r.payload_length = plen;
		r.alarm = info && ((seen_status & alarm_mask_reg) != 8'h00);
		awaited_results.push_back(r);
	endfunction

	// Advances the bench parser by one accepted word.
	function automatic void parse_word(input logic [7:0] b, input logic abort_bit);
		logic [7:0] idx;
		logic [7:0] plen;
		if (abort_bit) begin
			restart_scan();
			owe_result(sspp_pkg::KIND_ABORTED, 8'h00, 8'h00, 8'h00, 1'b0);
			return;
		end
		plen = seen_len - 8'd2;
		if (scan == SCAN_PAYLOAD) begin
			idx = body_count;
			csum = csum + b;
			body_count = body_count + 8'd1;
			if (body_count >= plen)
				scan = SCAN_CHECK;
			owe_result(sspp_pkg::KIND_PAYLOAD, b, idx, plen, 1'b1);
			return;
		end
		if (scan == SCAN_CHECK) begin
			restart_scan();
			if (~csum == b)
				owe_result(sspp_pkg::KIND_GOOD, 8'h00, 8'h00, plen, 1'b1);
			else
				owe_result(sspp_pkg::KIND_CHECKSUM, 8'h00, 8'h00, 8'h00, 1'b1);
			return;
		end
		case (hdr_count)
			3'd0, 3'd1: begin
				if (b != sspp_pkg::MARK_BYTE)
					hdr_bad = 1'b1;
			end
			3'd2: begin
				seen_id = b;
				if (b > sspp_pkg::MAX_ID)
					hdr_bad = 1'b1;
			end
			3'd3: begin
				seen_len = b;
				if (b < sspp_pkg::HDR_LEN_MIN)
					hdr_bad = 1'b1;
			end
			default: seen_status = b;
		endcase
		if (hdr_count < 3'd4) begin
			hdr_count = hdr_count + 3'd1;
			return;
		end
		plen = seen_len - 8'd2;
		if (hdr_bad) begin
			restart_scan();
			owe_result(sspp_pkg::KIND_BAD_HDR, 8'h00, 8'h00, 8'h00, 1'b1);
		end else if (plen > max_payload_reg) begin
			restart_scan();
			owe_result(sspp_pkg::KIND_TOO_LONG, 8'h00, 8'h00, 8'h00, 1'b1);
		end else begin
			csum = seen_id + seen_len + seen_status;
			body_count = '0;
			hdr_count = '0;
			hdr_bad = 1'b0;
			scan = (plen == 8'd0) ? SCAN_CHECK : SCAN_PAYLOAD;
		end
	endfunction

	task automatic flag_mismatch(input string msg);
		$display("MISMATCH: %s", msg);
		mismatches++;
	endtask

	task automatic check_field(input string name, input logic [7:0] got,
		input logic [7:0] want);
		if (got !== want)
			flag_mismatch($sformatf("result %0d %s: got %0h, expected %0h",
				results_seen, name, got, want));
	endtask

	task automatic check_result();
		sspp_pkg::result_t want;
		if (awaited_results.size() == 0) begin
			flag_mismatch($sformatf("result %0d arrived with none outstanding, kind %0d",
				results_seen, kind));
		end else begin
			want = awaited_results.pop_front();
			check_field("kind", {5'd0, kind}, {5'd0, want.kind});
			check_field("payload_byte", payload_byte, want.payload_byte);
			check_field("payload_index", payload_index, want.payload_index);
			check_field("packet_id", packet_id, want.packet_id);
			check_field("device_status", device_status, want.device_status);
			check_field("payload_length", payload_length, want.payload_length);
			check_field("alarm", {7'd0, alarm}, {7'd0, want.alarm});
		end
		results_seen++;
	endtask

	// Mostly no pause, some short ones and now and then a long one.
	function automatic int idle_length();
		int r;
		r = $urandom_range(0, 99);
		if (r < 65)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			rx_byte <= '0;
			abort <= 1'b0;
			gap_left = 0;
		end else begin
			if (in_valid && in_ready)
				parse_word(rx_byte, abort);
			if ($urandom_range(0, 149) == 0)
				drv_steady = !drv_steady;
			if (!in_valid || in_ready) begin
				if (gap_left > 0) begin
					gap_left--;
					in_valid <= 1'b0;
				end else if (rx_words.size() > 0) begin
					next_word = rx_words.pop_front();
					rx_byte <= next_word.data;
					abort <= next_word.abort_bit;
					in_valid <= 1'b1;
					gap_left = drv_steady ? 0 : idle_length();
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
			stall_left = 0;
		end else begin
			if (out_valid && out_ready)
				check_result();
			if ($urandom_range(0, 149) == 0)
				mon_steady = !mon_steady;
			if (stall_left > 0) begin
				stall_left--;
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
				if (!mon_steady)
					stall_left = idle_length();
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready) ||
					(cfg_valid && cfg_ready))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("simulation failed");
				$finish;
			end
		end
	end

	task automatic reg_write(input logic idx, input logic [7:0] value);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		do
			@(posedge clk);
		while (!cfg_ready);
		cfg_valid <= 1'b0;
		if (idx == sspp_pkg::REG_MAX_PAYLOAD)
			max_payload_reg = value;
		else
			alarm_mask_reg = value;
	endtask

	task automatic add_word(input logic [7:0] b, input logic abort_bit);
		rx_word_t w;
		w.data = b;
		w.abort_bit = abort_bit;
		rx_words.push_back(w);
		words_queued++;
	endtask

	// Builds a whole packet; flip is XORed into the closing checksum word.
	function automatic void build_frame(input logic [7:0] id, input logic [7:0] len,
		input logic [7:0] status, input logic [7:0] flip);
		logic [7:0] sum;
		logic [7:0] b;
		int n;
		frame.delete();
		frame.push_back(sspp_pkg::MARK_BYTE);
		frame.push_back(sspp_pkg::MARK_BYTE);
		frame.push_back(id);
		frame.push_back(len);
		frame.push_back(status);
		sum = id + len + status;
		n = (len < 8'd2) ? 0 : int'(len) - 2;
		for (int i = 0; i < n; i++) begin
			b = 8'($urandom);
			frame.push_back(b);
			sum = sum + b;
		end
		frame.push_back(~sum ^ flip);
	endfunction

	task automatic send_frame(input int count);
		for (int i = 0; i < count && i < frame.size(); i++)
			add_word(frame[i], 1'b0);
	endtask

	// Returns once every word is taken and every result is in, plus a margin
	// for header words still in flight that cause no result.
	task automatic wait_quiet();
		do
			@(negedge clk);
		while (rx_words.size() != 0 || in_valid || awaited_results.size() != 0);
		repeat (4) @(posedge clk);
	endtask

	task automatic random_phase(input logic [7:0] limit, input logic [7:0] mask,
		input int budget, input bit full_size);
		int goal;
		int r;
		int hi;
		int plen;
		logic [7:0] flip;
		reg_write(sspp_pkg::REG_MAX_PAYLOAD, limit);
		reg_write(sspp_pkg::REG_ALARM_MASK, mask);
		@(negedge clk);
		goal = words_queued + budget;
		if (full_size) begin
			build_frame(8'($urandom_range(0, 253)), 8'd255, 8'($urandom), 8'h00);
			send_frame(frame.size());
		end
		while (words_queued < goal) begin
			r = $urandom_range(0, 99);
			if (r < 70) begin
				hi = (max_payload_reg < 8) ? max_payload_reg : 8;
				plen = ($urandom_range(0, 4) != 0) ? $urandom_range(0, hi) :
					$urandom_range(0, 12);
				flip = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(1, 255)) : 8'h00;
				build_frame(8'($urandom_range(0, 253)), 8'(plen + 2), 8'($urandom), flip);
				send_frame(plen > max_payload_reg ? 5 : frame.size());
			end else if (r < 78) begin
				build_frame(8'($urandom_range(0, 253)), 8'($urandom_range(2, 9)),
					8'($urandom), 8'h00);
				case ($urandom_range(0, 3))
					0: frame[0] = 8'($urandom_range(0, 254));
					1: frame[1] = 8'($urandom_range(0, 254));
					2: frame[2] = 8'($urandom_range(254, 255));
					default: frame[3] = 8'($urandom_range(0, 1));
				endcase
				send_frame(5);
			end else if (r < 84 && max_payload_reg < 8'd253) begin
				build_frame(8'($urandom_range(0, 253)),
					8'($urandom_range(int'(max_payload_reg) + 3, 255)), 8'($urandom), 8'h00);
				send_frame(5);
			end else if (r < 92) begin
				// Packet cut short by a timeout at any point.
				build_frame(8'($urandom_range(0, 253)), 8'($urandom_range(2, 8)),
					8'($urandom), 8'h00);
				send_frame($urandom_range(0, frame.size()));
				add_word(8'($urandom), 1'b1);
			end else begin
				repeat ($urandom_range(1, 6))
					add_word(8'($urandom), $urandom_range(0, 4) == 0);
				if ($urandom_range(0, 9) < 7)
					add_word(8'($urandom), 1'b1);
			end
		end
		// Leave the parser at the start of a header before the next register write.
		add_word(8'($urandom), 1'b1);
		wait_quiet();
	endtask

	initial begin
		max_payload_reg = sspp_pkg::MAX_PAYLOAD_RST;
		alarm_mask_reg = sspp_pkg::ALARM_MASK_RST;
		restart_scan();
		seen_id = '0;
		seen_len = '0;
		seen_status = '0;
		csum = '0;
		body_count = '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		reg_write(sspp_pkg::REG_MAX_PAYLOAD, 8'd4);
		reg_write(sspp_pkg::REG_ALARM_MASK, 8'hFF);
		@(negedge clk);
		// Timeout with no byte received.
		add_word(8'h00, 1'b1);
		// Good packet with the highest legal id.
		build_frame(sspp_pkg::MAX_ID, 8'd4, 8'hFF, 8'h00);
		send_frame(frame.size());
		// Empty payload whose checksum is off.
		build_frame(8'h00, 8'd2, 8'h00, 8'h01);
		send_frame(frame.size());
		// Second mark is wrong.
		build_frame(8'h01, 8'd5, 8'h20, 8'h00);
		frame[1] = 8'h7F;
		send_frame(5);
		// Payload longer than the register allows.
		build_frame(8'h01, 8'd7, 8'h40, 8'h00);
		send_frame(5);
		// Timeout in the middle of the header.
		build_frame(8'h03, 8'd3, 8'h00, 8'h00);
		send_frame(3);
		add_word(8'hFF, 1'b1);
		wait_quiet();

		random_phase(8'd253, 8'hFF, 160, 1'b0);
		random_phase(8'd0, 8'h00, 160, 1'b0);
		random_phase(8'd7, 8'h81, 160, 1'b0);
		random_phase(8'd253, 8'h5A, 160, 1'b1);

		if (mismatches == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
